>>> hw/rtl/msis_pkg.sv
//------------------------------------------------------------------------------
// msis_pkg
// Shared types, codes and the braking distance table of the motor controller.
//------------------------------------------------------------------------------
`default_nettype none
package msis_pkg;

  localparam int unsigned BrakeTableSize = 350;
  localparam int unsigned MotorCount     = 2;

  localparam logic [15:0] StopTicksReset   = 16'd4000;
  localparam logic [14:0] SearchSpeedReset = 15'd100;
  localparam logic [19:0] FwdSpanReset     = 20'd6000;
  localparam logic [19:0] RevSpanReset     = 20'd12000;
  localparam logic [15:0] ArrivalReset     = 16'd50;
  localparam logic [15:0] RunSpeedReset    = 16'd64;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_SPEED  = 3'd1,
    ACT_RUN    = 3'd2,
    ACT_BRAKE  = 3'd3,
    ACT_SEEK   = 3'd4,
    ACT_FIND   = 3'd5,
    ACT_READ   = 3'd6,
    ACT_UNUSED = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    M_STOPPED = 3'd0,
    M_RUNNING = 3'd1,
    M_SEEKING = 3'd2,
    M_FINDING = 3'd3,
    M_BRAKING = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    P_START    = 3'd0,
    P_FWD      = 3'd1,
    P_BRK_FWD  = 3'd2,
    P_REV      = 3'd3,
    P_BRK_REV  = 3'd4,
    P_BRK_MARK = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    DRV_NONE  = 2'd0,
    DRV_SPEED = 2'd1,
    DRV_BRAKE = 2'd2
  } drive_t;

  typedef enum logic [2:0] {
    REG_STOP_TICKS = 3'd0,
    REG_SEARCH_SPD = 3'd1,
    REG_FWD_SPAN   = 3'd2,
    REG_REV_SPAN   = 3'd3,
    REG_ARRIVAL    = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [2:0]  action;
    logic        motor;
    logic [31:0] command_value;
    logic [31:0] encoder_angle;
    logic [15:0] ticks_at_angle;
    logic [7:0]  new_errors;
    logic        index_seen;
  } item_t;

  typedef struct packed {
    logic [1:0]  drive_mode;
    logic [15:0] drive_speed;
    logic        arm_index_reset;
    logic        just_stopped;
    logic [31:0] angle_out;
    logic [7:0]  error_total;
  } result_t;

  typedef struct packed {
    logic [15:0] stop_ticks;
    logic [14:0] search_speed;
    logic [19:0] forward_search_span;
    logic [19:0] reverse_search_span;
    logic [15:0] arrival_window;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] run_speed;
    logic [7:0]  error_count;
    logic [31:0] goal_angle;
    logic [15:0] seek_dir;
    phase_t      phase;
    logic [31:0] search_start;
    logic [31:0] search_limit;
  } chan_t;

  localparam logic [15:0] BRAKE_ROM [350] = '{
    0,0,0,8900,8100,7300,6500,5800,5082,4740,
    4108,3592,3160,2904,2588,2340,2128,1932,1741,1656,
    1497,1392,1257,1205,1136,1092,1012,937,901,840,
    781,764,720,689,664,637,613,585,552,540,
    533,505,481,465,456,441,440,405,392,381,
    377,373,357,353,333,313,305,301,301,293,
    289,285,284,273,268,245,245,237,229,229,
    229,221,217,217,217,213,209,209,208,201,
    201,197,193,193,181,157,157,157,149,145,
    145,145,141,141,141,141,137,137,137,137,
    136,133,133,133,133,133,129,128,125,125,
    125,125,125,121,121,121,121,117,117,116,
    113,113,113,105,81,81,77,77,77,77,
    73,73,73,73,73,73,73,69,69,69,
    69,69,69,69,69,68,65,65,65,65,
    65,65,65,65,65,65,61,61,61,61,
    61,61,61,61,61,61,61,61,61,61,
    57,57,57,57,57,57,57,57,57,57,
    57,57,57,57,57,57,57,57,57,57,
    53,53,53,53,53,53,53,53,53,53,
    53,53,53,53,53,53,53,53,53,53,
    53,53,53,49,49,49,49,49,49,49,
    49,49,49,49,49,49,49,49,49,49,
    49,49,49,49,49,49,49,49,49,49,
    49,49,45,45,45,45,45,45,45,45,
    45,45,45,45,45,45,45,45,45,45,
    45,45,45,45,45,45,45,45,45,45,
    45,45,45,45,45,45,45,45,45,45,
    41,41,41,41,41,41,41,41,41,41,
    41,41,41,41,41,41,41,41,41,41,
    41,41,41,41,41,41,41,41,41,41,
    41,41,41,41,41,41,41,41,41,41,
    41,41,37,37,37,37,37,37,37,37,
    37,37,37,37,37,37,37,37,37,37,
    37,37,37,37,37,37,37,37,37,37
  };

  function automatic logic [15:0] brake_dist(input logic [15:0] ticks);
    logic [15:0] d;
    d = 16'd0;
    if (32'(ticks) < BrakeTableSize && 32'(ticks) < 32'd350) begin
      d = BRAKE_ROM[ticks[8:0]];
    end
    return d;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [20:0] b);
    logic signed [33:0] s;
    s = 34'(signed'(a)) + 34'(signed'(b));
    if (s > 34'sd2147483647) return 32'h7fffffff;
    if (s < -34'sd2147483648) return 32'h80000000;
    return s[31:0];
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/msis_if.sv
//------------------------------------------------------------------------------
// msis_item_if / msis_result_if / msis_cfg_if
// Valid/ready channels of the motor controller.
//------------------------------------------------------------------------------
`default_nettype none
interface msis_item_if import msis_pkg::*; ;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface msis_result_if import msis_pkg::*; ;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface msis_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/msis_cfg_regs.sv
//------------------------------------------------------------------------------
// msis_cfg_regs
// Configuration register file.
//------------------------------------------------------------------------------
`default_nettype none
module msis_cfg_regs import msis_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  msis_cfg_if.sink  cfg,
  output cfg_t      regs
);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.stop_ticks          <= StopTicksReset;
      regs.search_speed        <= SearchSpeedReset;
      regs.forward_search_span <= FwdSpanReset;
      regs.reverse_search_span <= RevSpanReset;
      regs.arrival_window      <= ArrivalReset;
    end else if (cfg.valid) begin
      case (reg_index_t'(cfg.index))
        REG_STOP_TICKS: regs.stop_ticks          <= cfg.wdata[15:0];
        REG_SEARCH_SPD: regs.search_speed        <= cfg.wdata[14:0];
        REG_FWD_SPAN:   regs.forward_search_span <= cfg.wdata[19:0];
        REG_REV_SPAN:   regs.reverse_search_span <= cfg.wdata[19:0];
        REG_ARRIVAL:    regs.arrival_window      <= cfg.wdata[15:0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/msis_step.sv
//------------------------------------------------------------------------------
// msis_step
// Next channel state and result for one word.
//------------------------------------------------------------------------------
`default_nettype none
module msis_step import msis_pkg::*; #(
  parameter int unsigned BRAKE_TABLE_SIZE = BrakeTableSize
) (
  input  item_t   item,
  input  chan_t   cur,
  input  cfg_t    regs,
  output chan_t   nxt,
  output result_t res
);
  logic [31:0] ang;
  logic [7:0]  err_sum;
  logic        stop_ok;

  assign ang     = item.encoder_angle;
  assign err_sum = cur.error_count + item.new_errors;
  assign stop_ok = item.ticks_at_angle >= regs.stop_ticks;

  function automatic logic [15:0] bdist(input logic [15:0] t);
    logic [15:0] d;
    d = brake_dist(t);
    if (32'(t) >= BRAKE_TABLE_SIZE) d = 16'd0;
    return d;
  endfunction

  always_comb begin
    logic [31:0] tgt;
    logic [15:0] dir;
    logic [15:0] mag;
    logic signed [32:0] rem;
    logic        do_seek;
    nxt = cur;
    res = '0;
    tgt = cur.goal_angle;
    do_seek = 1'b0;
    mag = '0;
    rem = '0;
    unique case (action_t'(item.action))
      ACT_TICK: begin
        if (cur.mode == M_SEEKING) begin
          nxt.error_count = err_sum;
          do_seek = 1'b1;
        end else if (cur.mode == M_BRAKING) begin
          nxt.error_count = err_sum;
          if (stop_ok) begin
            res.just_stopped = 1'b1;
            nxt.mode = M_STOPPED;
          end
        end else if (cur.mode == M_FINDING) begin
          priority case (cur.phase)
            P_START: begin
              res.arm_index_reset = 1'b1;
              nxt.error_count = err_sum;
              nxt.search_limit = sat_add(ang, {1'b0, regs.forward_search_span});
              nxt.search_start = ang;
              res.drive_mode = DRV_SPEED;
              res.drive_speed = {1'b0, regs.search_speed};
              nxt.phase = P_FWD;
            end
            P_FWD, P_REV: begin
              if (item.index_seen) begin
                res.drive_mode = DRV_BRAKE;
                nxt.phase = P_BRK_MARK;
              end else begin
                nxt.error_count = err_sum;
                if (cur.phase == P_FWD ? signed'(ang) >= signed'(cur.search_limit)
                                       : signed'(ang) <= signed'(cur.search_limit)) begin
                  res.drive_mode = DRV_BRAKE;
                  nxt.phase = (cur.phase == P_FWD) ? P_BRK_FWD : P_BRK_REV;
                end
              end
            end
            P_BRK_FWD: begin
              nxt.error_count = err_sum;
              if (stop_ok) begin
                nxt.search_limit = sat_add(ang, -21'(signed'({1'b0, regs.reverse_search_span})));
                res.drive_mode = DRV_SPEED;
                res.drive_speed = -{1'b0, regs.search_speed};
                nxt.phase = P_REV;
              end
            end
            P_BRK_REV, P_BRK_MARK: begin
              nxt.error_count = err_sum;
              if (stop_ok) begin
                tgt = (cur.phase == P_BRK_REV) ? cur.search_start : 32'd0;
                nxt.mode = M_SEEKING;
                nxt.goal_angle = tgt;
                nxt.seek_dir = 16'd0;
                do_seek = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ACT_SPEED: begin
        if (signed'(item.command_value) > 32'sd32767) nxt.run_speed = 16'h7fff;
        else if (signed'(item.command_value) < -32'sd32768) nxt.run_speed = 16'h8000;
        else nxt.run_speed = item.command_value[15:0];
        if (cur.mode == M_RUNNING) begin
          res.drive_mode = DRV_SPEED;
          res.drive_speed = nxt.run_speed;
        end
      end
      ACT_RUN: begin
        nxt.mode = M_RUNNING;
        res.drive_mode = DRV_SPEED;
        res.drive_speed = cur.run_speed;
      end
      ACT_BRAKE: begin
        if (cur.mode == M_RUNNING || cur.mode == M_SEEKING || cur.mode == M_FINDING) begin
          res.drive_mode = DRV_BRAKE;
          nxt.mode = M_BRAKING;
        end
      end
      ACT_SEEK: begin
        nxt.error_count = err_sum;
        tgt = item.command_value;
        nxt.mode = M_SEEKING;
        nxt.goal_angle = tgt;
        nxt.seek_dir = 16'd0;
        do_seek = 1'b1;
      end
      ACT_FIND: begin
        nxt.mode = M_FINDING;
        nxt.phase = P_START;
      end
      ACT_READ: begin
        res.angle_out = ang;
        res.error_total = err_sum;
        nxt.error_count = 8'd0;
      end
      ACT_UNUSED: ;
    endcase

    // seek step on the updated direction
    dir = nxt.seek_dir;
    if (do_seek) begin
      if (dir == 16'd0) begin
        mag = cur.run_speed[15] ? -cur.run_speed : cur.run_speed;
        if (mag == 16'h8000) mag = 16'h7fff;
        dir = (signed'(tgt) > signed'(ang)) ? mag : -mag;
        nxt.seek_dir = dir;
      end
      rem = dir[15] ? (33'(signed'(ang)) - 33'(signed'(tgt)))
                    : (33'(signed'(tgt)) - 33'(signed'(ang)));
      if (dir == 16'd0) rem = 33'(signed'(ang)) - 33'(signed'(tgt));
      if (rem <= signed'({17'd0, regs.arrival_window})) begin
        res.drive_mode = DRV_BRAKE;
        nxt.mode = M_BRAKING;
      end else if (rem <= signed'({17'd0, bdist(item.ticks_at_angle)})) begin
        res.drive_mode = DRV_BRAKE;
      end else begin
        res.drive_mode = DRV_SPEED;
        res.drive_speed = dir;
      end
    end
    if (res.drive_mode != DRV_SPEED) res.drive_speed = 16'd0;
  end
endmodule
`default_nettype wire

>>> hw/rtl/motor_seek_and_index_search.sv
//------------------------------------------------------------------------------
// motor_seek_and_index_search
// Two-channel motor seek and index search controller.
//------------------------------------------------------------------------------
// in_ch carries one word per command or tick: action, motor number, command
// value and the motor's encoder reading. out_ch returns exactly one result
// word per input word. cfg is a register write port, always ready.
// Each word is registered at the input, then the channel state and the
// result are computed combinationally from that register and the per-motor
// state registers; the result lands in the output register. One word per
// cycle is sustained while out_ch is not stalled.
// The next word's state read sees the previous word's update, so words for
// the same motor may follow back to back.
// A stalled out_ch holds its word; the input register still takes a new word
// while the output register waits, then in_ch.ready drops until it drains.
// Reset clears all motors to stopped, run speed 64, zero errors, and loads
// the register defaults.
//------------------------------------------------------------------------------
`default_nettype none
module motor_seek_and_index_search import msis_pkg::*; #(
  parameter int unsigned BRAKE_TABLE_SIZE = BrakeTableSize,
  parameter int unsigned MOTOR_COUNT      = MotorCount
) (
  input  wire logic     clk,
  input  wire logic     rst,
  msis_item_if.sink     in_ch,
  msis_result_if.source out_ch,
  msis_cfg_if.sink      cfg
);
  cfg_t    regs;
  chan_t   chans [MOTOR_COUNT];
  item_t   stage;
  logic    stage_valid;
  logic    advance;
  chan_t   cur, nxt;
  result_t res;
  logic    hit;

  msis_cfg_regs u_cfg (.clk(clk), .rst(rst), .cfg(cfg), .regs(regs));

  assign advance     = stage_valid && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready = !stage_valid || advance;
  assign hit         = 32'(stage.motor) < MOTOR_COUNT;

  always_comb begin
    cur = chans[0];
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      if (32'(stage.motor) == i) cur = chans[i];
    end
  end

  msis_step #(.BRAKE_TABLE_SIZE(BRAKE_TABLE_SIZE)) u_step (
    .item(stage), .cur(cur), .regs(regs), .nxt(nxt), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ch.ready) begin
      stage_valid <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      stage <= in_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (advance) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
    if (advance) begin
      out_ch.data <= hit ? res : '0;
    end
  end

  for (genvar g = 0; g < MOTOR_COUNT; g++) begin : g_chan
    always_ff @(posedge clk) begin
      if (rst) begin
        chans[g].mode         <= M_STOPPED;
        chans[g].run_speed    <= RunSpeedReset;
        chans[g].error_count  <= 8'd0;
        chans[g].goal_angle   <= 32'd0;
        chans[g].seek_dir     <= 16'd0;
        chans[g].phase        <= P_START;
      end else if (advance && hit && 32'(stage.motor) == g) begin
        chans[g].mode         <= nxt.mode;
        chans[g].run_speed    <= nxt.run_speed;
        chans[g].error_count  <= nxt.error_count;
        chans[g].goal_angle   <= nxt.goal_angle;
        chans[g].seek_dir     <= nxt.seek_dir;
        chans[g].phase        <= nxt.phase;
      end
      if (advance && hit && 32'(stage.motor) == g) begin
        chans[g].search_start <= nxt.search_start;
        chans[g].search_limit <= nxt.search_limit;
      end
    end
  end
endmodule
`default_nettype wire
